// ----- src/mtrg_pkg.sv -----
package mtrg_pkg;

    localparam int unsigned STATE_WORDS  = 624;
    localparam int unsigned TWIST_OFFSET = 397;
    localparam int unsigned ADDR_W       = $clog2(STATE_WORDS);
    localparam int unsigned IDX_W        = $clog2(STATE_WORDS + 1);

    localparam logic [31:0] SEED_RESET   = 32'd5489;
    localparam logic [31:0] TWIST_MATRIX = 32'h9908_b0df;
    localparam logic [31:0] HIGH_BIT     = 32'h8000_0000;
    localparam logic [31:0] LOW_BITS     = 32'h7fff_ffff;
    localparam logic [31:0] INIT_MULT    = 32'd1812433253;
    localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
    localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;

    typedef struct packed {
        logic [31:0] range_min;
        logic [31:0] range_max;
    } req_t;

    typedef struct packed {
        logic [31:0] value;
        logic        bad_range;
    } rsp_t;

endpackage

// ----- src/mtrg_ram.sv -----
module mtrg_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 624
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, two registered read ports
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ----- src/mtrg_div.sv -----
module mtrg_div
    import mtrg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [32:0] divisor,
    output logic        busy,
    output logic        done,
    output logic [31:0] remainder
);

    logic [31:0] rem_reg, rem_next;
    logic [31:0] dvd_reg, dvd_next;
    logic [32:0] dsr_reg, dsr_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] shifted;
    logic [32:0] diff;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        shifted   = {rem_reg, dvd_reg[31]};
        diff      = shifted - dsr_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (shifted >= dsr_reg) begin
                rem_next = diff[31:0];
            end else begin
                rem_next = shifted[31:0];
            end
            dvd_next = {dvd_reg[30:0], 1'b0};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ----- src/mt19937_ranged_generator.sv -----
// MT19937 ranged generator: each request beat carries an inclusive range_min and
// range_max and returns range_min + (tempered word mod (range_max - range_min + 1)),
// or value 0 with bad_range set when range_min >= range_max (the state is then left
// alone). A normal request reads the word, tempers it and hands it to the 32-step
// restoring divider that reduces the word to the range; the input opens again when
// the result is loaded, so a new request is never taken before the last is done. Every
// 624th word first regenerates the table, with each word read and then rewritten over
// the single table RAM. After reset, and after every seed write, the table is refilled
// from the seed (one 32x32 multiply per word after the first) and no request is taken
// until that is done. A refused range goes straight to S_DONE, skipping the table and
// the divider; the input again stays closed until the refusal is loaded into the output.
// A request may be accepted while the previous result still waits on the output.
module mt19937_ranged_generator
    import mtrg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  req_t        s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output rsp_t        m_data
);

    localparam logic [3:0] S_FILL0    = 4'd0;
    localparam logic [3:0] S_FILL_MUL = 4'd1;
    localparam logic [3:0] S_FILL_WR  = 4'd2;
    localparam logic [3:0] S_IDLE     = 4'd3;
    localparam logic [3:0] S_TW_PRE   = 4'd4;
    localparam logic [3:0] S_TW_LD    = 4'd5;
    localparam logic [3:0] S_TW_RD    = 4'd6;
    localparam logic [3:0] S_TW_WR    = 4'd7;
    localparam logic [3:0] S_RD       = 4'd8;
    localparam logic [3:0] S_TEMP     = 4'd9;
    localparam logic [3:0] S_DIV      = 4'd10;
    localparam logic [3:0] S_DONE     = 4'd11;

    localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(STATE_WORDS - 1);
    localparam logic [ADDR_W-1:0] WRAP_AT   = ADDR_W'(STATE_WORDS - TWIST_OFFSET);
    localparam logic [ADDR_W-1:0] FAR_FWD   = ADDR_W'(TWIST_OFFSET);
    localparam logic [IDX_W-1:0]  IDX_FULL  = IDX_W'(STATE_WORDS);

    function automatic logic [31:0] temper(input logic [31:0] w);
        logic [31:0] y;
        y = w ^ (w >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    logic [3:0]        state_reg, state_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0]  read_index_reg, read_index_next;
    logic [31:0]       word_reg, word_next;
    logic [31:0]       mul_reg, mul_next;
    logic [31:0]       lo_reg, lo_next;
    logic [31:0]       hi_reg, hi_next;
    rsp_t              res_reg, res_next;
    logic              m_valid_reg, m_valid_next;
    rsp_t              m_data_reg, m_data_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [31:0]       ram_wdata;
    logic [ADDR_W-1:0] ram_raddr_a;
    logic [ADDR_W-1:0] ram_raddr_b;
    logic [31:0]       ram_rdata_a;
    logic [31:0]       ram_rdata_b;

    logic              div_start;
    logic              div_busy;
    logic              div_done;
    logic [31:0]       div_rem;
    logic [32:0]       span;

    logic [31:0]       fill_word;
    logic [31:0]       mix;
    logic [31:0]       twist_y;
    logic [31:0]       twist_v;
    logic [ADDR_W-1:0] next_addr;
    logic [ADDR_W-1:0] far_addr;

    mtrg_ram #(
        .WIDTH(32),
        .DEPTH(STATE_WORDS)
    ) u_table (
        .aclk    (aclk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .raddr_b (ram_raddr_b),
        .rdata_a (ram_rdata_a),
        .rdata_b (ram_rdata_b)
    );

    mtrg_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (temper(ram_rdata_a)),
        .divisor   (span),
        .busy      (div_busy),
        .done      (div_done),
        .remainder (div_rem)
    );

    // seed recurrence and twist datapath
    assign span      = {1'b0, hi_reg} - {1'b0, lo_reg} + 33'd1;
    assign mix       = word_reg ^ (word_reg >> 30);
    assign mul_next  = mix * INIT_MULT;
    assign fill_word = mul_reg + 32'(idx_reg);
    assign next_addr = (idx_reg == LAST_WORD) ? '0 : idx_reg + 1'b1;
    assign far_addr  = (idx_reg >= WRAP_AT) ? idx_reg - WRAP_AT : idx_reg + FAR_FWD;
    assign twist_y   = (word_reg & HIGH_BIT) | (ram_rdata_a & LOW_BITS);
    assign twist_v   = ram_rdata_b ^ (twist_y >> 1) ^ (twist_y[0] ? TWIST_MATRIX : 32'd0);

    // sequencer
    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        read_index_next = read_index_reg;
        word_next       = word_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        res_next        = res_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = fill_word;
        ram_raddr_a     = idx_reg;
        ram_raddr_b     = far_addr;
        div_start       = 1'b0;

        unique case (state_reg)
            S_FILL0: begin
                ram_we     = 1'b1;
                ram_waddr  = '0;
                ram_wdata  = word_reg;
                idx_next   = ADDR_W'(1);
                state_next = S_FILL_MUL;
            end
            S_FILL_MUL: begin
                state_next = S_FILL_WR;
            end
            S_FILL_WR: begin
                ram_we    = 1'b1;
                word_next = fill_word;
                if (idx_reg == LAST_WORD) begin
                    read_index_next = IDX_FULL;
                    state_next      = S_IDLE;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_FILL_MUL;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    lo_next = s_data.range_min;
                    hi_next = s_data.range_max;
                    if (s_data.range_min >= s_data.range_max) begin
                        res_next   = '{value: 32'd0, bad_range: 1'b1};
                        state_next = S_DONE;
                    end else if (read_index_reg >= IDX_FULL) begin
                        state_next = S_TW_PRE;
                    end else begin
                        state_next = S_RD;
                    end
                end
            end
            S_TW_PRE: begin
                ram_raddr_a = '0;
                idx_next    = '0;
                state_next  = S_TW_LD;
            end
            S_TW_LD: begin
                word_next  = ram_rdata_a;
                state_next = S_TW_RD;
            end
            S_TW_RD: begin
                ram_raddr_a = next_addr;
                ram_raddr_b = far_addr;
                state_next  = S_TW_WR;
            end
            S_TW_WR: begin
                ram_we    = 1'b1;
                ram_wdata = twist_v;
                word_next = ram_rdata_a;
                if (idx_reg == LAST_WORD) begin
                    read_index_next = '0;
                    state_next      = S_RD;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_TW_RD;
                end
            end
            S_RD: begin
                ram_raddr_a     = read_index_reg[ADDR_W-1:0];
                read_index_next = read_index_reg + 1'b1;
                state_next      = S_TEMP;
            end
            S_TEMP: begin
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    res_next   = '{value: lo_reg + div_rem, bad_range: 1'b0};
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // seed write restarts the table fill
        if (cfg_we) begin
            word_next  = cfg_wdata;
            state_next = S_FILL0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_FILL0;
            idx_reg        <= '0;
            read_index_reg <= IDX_FULL;
            word_reg       <= SEED_RESET;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            read_index_reg <= read_index_next;
            word_reg       <= word_next;
            m_valid_reg    <= m_valid_next;
        end
        mul_reg    <= mul_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    // a seed write always closes the input until the refill is done
    assert property (@(posedge aclk) disable iff (!aresetn) cfg_we |=> !s_ready)
        else $error("input open right after seed write");

    // read index never runs past the table
    assert property (@(posedge aclk) disable iff (!aresetn) read_index_reg <= IDX_FULL)
        else $error("read index past table end");

    // refused range always comes back as zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.bad_range) |-> (m_data.value == 32'd0))
        else $error("refused range with nonzero value");

    // divider only started when idle
    assert property (@(posedge aclk) disable iff (!aresetn) div_start |-> !div_busy)
        else $error("divider restarted while busy");
`endif

endmodule
